>>> rtl/imuca_pkg.sv
// Package for the complementary attitude unit: widths, atan table, shared types.
// No dependencies.
package imuca_pkg;

    localparam int AXIS_W        = 16;
    localparam int ANGLE_W       = 17;
    localparam int WEIGHT_W      = 17;
    localparam int GAIN_W        = 24;
    localparam int CFG_W         = 24;
    localparam int CORDIC_W      = 28;   // x/y datapath: |v| < 2^25.5 after growth
    localparam int Z_W           = 26;   // Q16 degrees, +-180 deg fits
    localparam int ATAN_ENTRIES  = 24;
    localparam int STEPS_DEFAULT = 16;
    localparam int SQRT_IN_W     = 48;
    localparam int SQRT_OUT_W    = 24;
    localparam int LANES         = 3;

    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd62915;
    localparam logic [GAIN_W-1:0]   GAIN_RESET   = 24'd327855;
    localparam logic [WEIGHT_W-1:0] ONE_Q16      = 17'd65536;

    localparam logic CFG_IDX_WEIGHT = 1'b0;
    localparam logic CFG_IDX_GAIN   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQRT,
        ST_CORDIC,
        ST_BLEND,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic start;
        logic done;
    } lane_ctrl_t;

    function automatic logic [Z_W-1:0] atan_q16(input logic [4:0] idx);
        logic [Z_W-1:0] v;
        unique case (idx)
            5'd0:  v = 26'd2949120;
            5'd1:  v = 26'd1740967;
            5'd2:  v = 26'd919879;
            5'd3:  v = 26'd466945;
            5'd4:  v = 26'd234379;
            5'd5:  v = 26'd117304;
            5'd6:  v = 26'd58666;
            5'd7:  v = 26'd29335;
            5'd8:  v = 26'd14668;
            5'd9:  v = 26'd7334;
            5'd10: v = 26'd3667;
            5'd11: v = 26'd1833;
            5'd12: v = 26'd917;
            5'd13: v = 26'd458;
            5'd14: v = 26'd229;
            5'd15: v = 26'd115;
            5'd16: v = 26'd57;
            5'd17: v = 26'd29;
            5'd18: v = 26'd14;
            5'd19: v = 26'd7;
            5'd20: v = 26'd4;
            5'd21: v = 26'd2;
            5'd22: v = 26'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/imuca_sqrt.sv
// Bit-serial integer square root, one result bit per cycle.
// Depends on imuca_pkg.
module imuca_sqrt (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [imuca_pkg::SQRT_IN_W-1:0]  radicand,
    output logic                             done,
    output logic [imuca_pkg::SQRT_OUT_W-1:0] root
);
    import imuca_pkg::*;

    logic [SQRT_IN_W-1:0]   rem_reg, rem_next;
    logic [SQRT_IN_W-1:0]   res_reg, res_next;
    logic [SQRT_IN_W-1:0]   bit_reg, bit_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [SQRT_IN_W-1:0]   trial;

    // restoring square root, one result bit per cycle
    always_comb begin
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = res_reg + bit_reg;
        if (start) begin
            rem_next  = radicand;
            res_next  = '0;
            bit_next  = {2'b01, {(SQRT_IN_W-2){1'b0}}};
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_reg >= trial) begin
                rem_next = rem_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0]) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign root = res_reg[SQRT_OUT_W-1:0];

endmodule

>>> rtl/imuca_cordic.sv
// Vectoring CORDIC lane: atan2(y, x) in Q16 degrees, one iteration per cycle.
// Depends on imuca_pkg.
module imuca_cordic #(
    parameter int STEPS = imuca_pkg::STEPS_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  imuca_pkg::lane_ctrl_t          ctrl_in,   // .start used
    input  logic signed [imuca_pkg::CORDIC_W-1:0] y_in,
    input  logic signed [imuca_pkg::CORDIC_W-1:0] x_in,
    output imuca_pkg::lane_ctrl_t          ctrl_out,  // .done pulses
    output logic signed [imuca_pkg::Z_W-1:0] angle
);
    import imuca_pkg::*;

    localparam int N_STEPS = (STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : STEPS;

    logic signed [CORDIC_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [Z_W-1:0]      z_reg, z_next;
    logic [4:0]                 i_reg, i_next;
    logic                       busy_reg, busy_next, done_reg, done_next;
    logic signed [CORDIC_W-1:0] dx, dy;
    logic signed [Z_W-1:0]      a_i;

    always_comb begin
        x_next = x_reg; y_next = y_reg; z_next = z_reg;
        i_next = i_reg; busy_next = busy_reg; done_next = 1'b0;
        dx  = y_reg >>> i_reg;
        dy  = x_reg >>> i_reg;
        a_i = signed'(atan_q16(i_reg));
        if (ctrl_in.start) begin
            i_next = '0;
            if (x_in == '0 && y_in == '0) begin
                x_next = '0; y_next = '0; z_next = '0;
                busy_next = 1'b0; done_next = 1'b1;
            end else begin
                busy_next = (N_STEPS != 0);
                done_next = (N_STEPS == 0);
                if (x_in < 0) begin
                    if (y_in >= 0) begin
                        z_next = Z_W'(90 * 65536); x_next = y_in; y_next = -x_in;
                    end else begin
                        z_next = -Z_W'(90 * 65536); x_next = -y_in; y_next = x_in;
                    end
                end else begin
                    z_next = '0; x_next = x_in; y_next = y_in;
                end
            end
        end else if (busy_reg) begin
            if (y_reg >= 0) begin
                x_next = x_reg + dx; y_next = y_reg - dy; z_next = z_reg + a_i;
            end else begin
                x_next = x_reg - dx; y_next = y_reg + dy; z_next = z_reg - a_i;
            end
            i_next = i_reg + 5'd1;
            if (i_reg == 5'(N_STEPS - 1)) begin
                busy_next = 1'b0; done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next; y_reg <= y_next; z_reg <= z_next; i_reg <= i_next;
        if (!aresetn) begin
            busy_reg <= 1'b0; done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next; done_reg <= done_next;
        end
    end

    always_comb begin
        ctrl_out.start = 1'b0;
        ctrl_out.done  = done_reg;
    end
    assign angle = z_reg;

endmodule

>>> rtl/imuca_blend.sv
// Merge stage: blends gyro-propagated and accelerometer angles for one axis.
// Depends on imuca_pkg. Three multiply steps, then round and saturate.
module imuca_blend (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic [imuca_pkg::WEIGHT_W-1:0]        weight,
    input  logic [imuca_pkg::GAIN_W-1:0]          gain,
    input  logic signed [imuca_pkg::AXIS_W-1:0]   gyro,
    input  logic signed [imuca_pkg::Z_W-1:0]      accel_angle,
    input  logic signed [imuca_pkg::ANGLE_W:0]    old_angle,
    output logic                                  done,
    output logic signed [imuca_pkg::ANGLE_W:0]    new_angle
);
    import imuca_pkg::*;

    logic [1:0]          ph_reg, ph_next;
    logic                done_reg, done_next;
    logic signed [42:0]  s_reg, s_next;      // old*2^24 + gyro*gain
    logic signed [80:0]  n_reg, n_next;
    logic [WEIGHT_W-1:0] a_sat;
    logic signed [17:0]  a_s, ia_s;
    logic signed [80:0]  v;
    logic signed [ANGLE_W:0] res_reg, res_next;

    assign a_sat = (weight > ONE_Q16) ? ONE_Q16 : weight;
    assign a_s   = signed'({1'b0, a_sat});
    assign ia_s  = signed'({1'b0, ONE_Q16 - a_sat});

    always_comb begin
        ph_next = ph_reg; done_next = 1'b0;
        s_next = s_reg; n_next = n_reg; res_next = res_reg;
        v = (n_reg + (81'sd1 <<< 39)) >>> 40;
        unique case (ph_reg)
            2'd0: if (start) begin
                s_next  = (43'(old_angle) <<< 24) + 43'(gyro * signed'({1'b0, gain}));
                ph_next = 2'd1;
            end
            2'd1: begin
                n_next  = 81'(s_reg * a_s);
                ph_next = 2'd2;
            end
            2'd2: begin
                n_next  = n_reg + ((81'(accel_angle * ia_s)) <<< 16);
                ph_next = 2'd3;
            end
            default: begin
                if (v > 81'sd65535)       res_next = 18'sd65535;
                else if (v < -81'sd65536) res_next = -18'sd65536;
                else                      res_next = v[ANGLE_W:0];
                done_next = 1'b1;
                ph_next   = 2'd0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        s_reg <= s_next; n_reg <= n_next;
        if (!aresetn) begin
            ph_reg <= 2'd0; done_reg <= 1'b0; res_reg <= '0;
        end else begin
            ph_reg <= ph_next; done_reg <= done_next; res_reg <= res_next;
        end
    end

    assign done      = done_reg;
    assign new_angle = res_reg;

endmodule

>>> rtl/imu_complementary_attitude_unit.sv
// Top level of the complementary attitude unit: control, config, lanes, output.
// Depends on imuca_pkg, imuca_sqrt, imuca_cordic, imuca_blend.
//
//  channel   dir  fields (tdata from bit 0 up)
//  s_axis    in   accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z (96 bits)
//  m_axis    out  pitch_angle, roll_angle, yaw_angle (51 bits + 5 zero bits)
//  cfg       in   cfg_we / cfg_addr / cfg_wdata: 0 blend_weight, 1 gyro_step_gain
//
// A result is offered after its word is accepted and has passed these steps:
// bit-serial square roots in two lanes, a load of the three CORDIC lanes, STEPS
// iterations side by side, the blend steps, and commit and present.
// Reset (synchronous, active low) clears the estimates and loads the default
// weight and gain. A result waits in the output register; the next word is
// accepted once it is taken.
module imu_complementary_attitude_unit #(
    parameter int CORDIC_STEPS = imuca_pkg::STEPS_DEFAULT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [55:0]  m_axis_tdata,   // pitch_angle, roll_angle, yaw_angle, pad
    input  logic         cfg_we,
    input  logic         cfg_addr,
    input  logic [imuca_pkg::CFG_W-1:0] cfg_wdata
);
    import imuca_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic [WEIGHT_W-1:0] weight_reg;
    logic [GAIN_W-1:0]   gain_reg;
    logic [95:0]         in_reg;
    logic signed [ANGLE_W:0] est_reg [LANES];
    logic                out_valid_reg;

    logic signed [AXIS_W-1:0] ax, ay, az;
    assign ax = in_reg[15:0];
    assign ay = in_reg[31:16];
    assign az = in_reg[47:32];

    // the square roots start on the accepting edge, so take their axes from the bus
    logic signed [AXIS_W-1:0] in_ax, in_ay, in_az;
    assign in_ax = s_axis_tdata[15:0];
    assign in_ay = s_axis_tdata[31:16];
    assign in_az = s_axis_tdata[47:32];

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg <= WEIGHT_RESET;
            gain_reg   <= GAIN_RESET;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_IDX_WEIGHT: weight_reg <= cfg_wdata[WEIGHT_W-1:0];
                default:        gain_reg   <= cfg_wdata;
            endcase
        end
    end

    // square-root lanes: |(ay,az)| and |(ax,ay)|
    logic start_sqrt, start_cordic, start_blend;
    logic sq_done0, sq_done1;
    logic [SQRT_OUT_W-1:0] m_yz, m_xy;
    logic [32:0] sq_yz, sq_xy;
    assign sq_yz = 33'(in_ay * in_ay) + 33'(in_az * in_az);
    assign sq_xy = 33'(in_ax * in_ax) + 33'(in_ay * in_ay);

    imuca_sqrt u_sqrt_yz (.aclk, .aresetn, .start(start_sqrt),
        .radicand({sq_yz[31:0], 16'd0}), .done(sq_done0), .root(m_yz));
    imuca_sqrt u_sqrt_xy (.aclk, .aresetn, .start(start_sqrt),
        .radicand({sq_xy[31:0], 16'd0}), .done(sq_done1), .root(m_xy));

    // CORDIC lanes
    logic signed [CORDIC_W-1:0] ly [LANES];
    logic signed [CORDIC_W-1:0] lx [LANES];
    logic signed [Z_W-1:0]      lz [LANES];
    lane_ctrl_t lc_in, lc_out [LANES];
    logic signed [AXIS_W-1:0]   lg [LANES];
    logic signed [ANGLE_W:0]    lnew [LANES];
    logic                       bl_done [LANES];

    always_comb begin
        lc_in.start = start_cordic;
        lc_in.done  = 1'b0;
        ly[0] = CORDIC_W'(ax) <<< 8;  lx[0] = CORDIC_W'(m_yz);
        ly[1] = CORDIC_W'(ay) <<< 8;  lx[1] = CORDIC_W'(az) <<< 8;
        ly[2] = CORDIC_W'(az) <<< 8;  lx[2] = CORDIC_W'(m_xy);
        lg[0] = in_reg[79:64];        // gyro_y -> pitch
        lg[1] = in_reg[63:48];        // gyro_x -> roll
        lg[2] = in_reg[95:80];        // gyro_z -> yaw
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        imuca_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (.aclk, .aresetn,
            .ctrl_in(lc_in), .y_in(ly[g]), .x_in(lx[g]),
            .ctrl_out(lc_out[g]), .angle(lz[g]));
        imuca_blend u_blend (.aclk, .aresetn, .start(start_blend),
            .weight(weight_reg), .gain(gain_reg), .gyro(lg[g]),
            .accel_angle(lz[g]), .old_angle(est_reg[g]),
            .done(bl_done[g]), .new_angle(lnew[g]));
    end

    // next-state logic
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_axis_tvalid && !out_valid_reg) state_next = ST_SQRT;
            ST_SQRT:   if (sq_done0 && sq_done1)            state_next = ST_CORDIC;
            ST_CORDIC: if (lc_out[0].done)                  state_next = ST_BLEND;
            ST_BLEND:  if (bl_done[0])                      state_next = ST_OUT;
            default:                                        state_next = ST_IDLE;
        endcase
    end

    // output logic
    always_comb begin
        s_axis_tready = (state_reg == ST_IDLE) && !out_valid_reg;
        start_sqrt    = (state_reg == ST_IDLE) && s_axis_tvalid && !out_valid_reg;
        start_cordic  = (state_reg == ST_SQRT) && sq_done0 && sq_done1;
        start_blend   = (state_reg == ST_CORDIC) && lc_out[0].done;
    end

    // hold the accepted word for the CORDIC and blend lanes
    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) in_reg <= s_axis_tdata;
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < LANES; k++) est_reg[k] <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_BLEND && bl_done[0]) begin
                for (int k = 0; k < LANES; k++) est_reg[k] <= lnew[k];
            end
            if (state_reg == ST_OUT)                 out_valid_reg <= 1'b1;
            else if (m_axis_tready && out_valid_reg) out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, est_reg[2][ANGLE_W-1:0], est_reg[1][ANGLE_W-1:0],
                            est_reg[0][ANGLE_W-1:0]};

endmodule
